// ===== rtl/lpht_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the linear probing hash table
package lpht_pkg;

    localparam int KEY_W     = 31;
    localparam int POS_W     = 5;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_SEARCH = 2'd2
    } t_command;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef struct packed {
        logic    load_in;
        logic    clear_step;
        logic    mod_step;
        logic    fetch;
        logic    advance;
        logic    write_key;
        logic    stage;
        t_status stage_status;
        logic    stage_use_slot;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_clear;
        logic is_insert;
        logic is_invalid;
        logic sweep_last;
        logic mod_last;
        logic slot_empty;
        logic slot_match;
        logic probes_last;
    } t_dp_stat;

endpackage

// ===== rtl/linear_probe_hash_table_core.sv =====
`timescale 1ns / 1ps
// Linear probing hash table of positive integer keys, top level.
//
// Input channel (i_in_valid / o_in_ready) carries a command and a key:
// clear, insert or search. Output channel (o_out_valid / i_out_ready)
// returns one item per input item: a status and a slot position.
// One item is in work at a time. After acceptance the block decodes the
// item, then:
//   clear: sweeps every slot of the memory to empty, then stages an OK result.
//   zero key or unknown command: stages an invalid result.
//   insert/search: reduces the key modulo TABLE_SIZE (reciprocal multiply,
//   remainder, correction), fetches the home slot, probes 1 to TABLE_SIZE
//   slots in turn (limited by the single memory read port), stages the result.
// o_in_ready returns in the cycle the result enters the output register,
// so the next item can start while a result waits.
// After reset the block sweeps all TABLE_SIZE slots to empty, holding
// o_in_ready low until the sweep ends. If the receiver stalls, a
// finished result holds in the output register and a second finished
// result waits inside the block until the first one is taken.
module linear_probe_hash_table_core #(
    parameter int TABLE_SIZE = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lpht_pkg::CMD_W-1:0]    i_command,
    input  logic [lpht_pkg::KEY_W-1:0]    i_key,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lpht_pkg::STATUS_W-1:0] o_status,
    output logic [lpht_pkg::POS_W-1:0]    o_position
);

    lpht_pkg::t_dp_cmd  dp_cmd;
    lpht_pkg::t_dp_stat dp_stat;

    lpht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    lpht_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_command  (i_command),
        .i_key      (i_key),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_status   (o_status),
        .o_position (o_position)
    );

endmodule

// ===== rtl/lpht_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine for the linear probing hash table
module lpht_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  lpht_pkg::t_dp_stat i_stat,
    output lpht_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_MOD,
        S_FETCH,
        S_PROBE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_stat.is_clear) begin
                    n_state = S_CLEAR;
                end else if (i_stat.is_invalid) begin
                    o_cmd.stage        = 1'b1;
                    o_cmd.stage_status = lpht_pkg::ST_INVALID;
                    n_state            = S_DONE;
                end else begin
                    n_state = S_MOD;
                end
            end
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.stage        = 1'b1;
                    o_cmd.stage_status = lpht_pkg::ST_OK;
                    n_state            = S_DONE;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_PROBE;
            end
            S_PROBE: begin
                if (i_stat.is_insert) begin
                    priority if (i_stat.slot_empty) begin
                        o_cmd.write_key      = 1'b1;
                        o_cmd.stage          = 1'b1;
                        o_cmd.stage_status   = lpht_pkg::ST_OK;
                        o_cmd.stage_use_slot = 1'b1;
                    end else if (i_stat.probes_last) begin
                        o_cmd.stage        = 1'b1;
                        o_cmd.stage_status = lpht_pkg::ST_FULL;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end else begin
                    priority if (i_stat.slot_empty) begin
                        o_cmd.stage        = 1'b1;
                        o_cmd.stage_status = lpht_pkg::ST_MISSING;
                    end else if (i_stat.slot_match) begin
                        o_cmd.stage          = 1'b1;
                        o_cmd.stage_status   = lpht_pkg::ST_OK;
                        o_cmd.stage_use_slot = 1'b1;
                    end else if (i_stat.probes_last) begin
                        o_cmd.stage        = 1'b1;
                        o_cmd.stage_status = lpht_pkg::ST_MISSING;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
                if (o_cmd.stage) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/lpht_dp.sv =====
`timescale 1ns / 1ps
// datapath: slot memory, reciprocal home slot reduction, probe walk, result registers
module lpht_dp #(
    parameter int TABLE_SIZE = 31
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [lpht_pkg::CMD_W-1:0]       i_command,
    input  logic [lpht_pkg::KEY_W-1:0]       i_key,
    input  lpht_pkg::t_dp_cmd                i_cmd,
    output lpht_pkg::t_dp_stat               o_stat,
    output logic [lpht_pkg::STATUS_W-1:0]    o_status,
    output logic [lpht_pkg::POS_W-1:0]       o_position
);

    localparam int SLOT_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int WIDE_W      = SLOT_W + 1;
    localparam int RECIP_SHIFT = 32;
    localparam int PROD_W      = lpht_pkg::KEY_W + RECIP_SHIFT;

    localparam logic [SLOT_W-1:0]          LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);
    localparam logic [WIDE_W-1:0]          SIZE_WIDE = WIDE_W'(TABLE_SIZE);
    localparam logic [lpht_pkg::KEY_W-1:0] SIZE_KEY  = lpht_pkg::KEY_W'(TABLE_SIZE);
    localparam logic [RECIP_SHIFT-1:0]     RECIP     =
        RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / TABLE_SIZE);
    localparam logic [1:0]                 MOD_LAST_STEP = 2'd2;

    logic [lpht_pkg::KEY_W-1:0] mem [TABLE_SIZE];

    logic [lpht_pkg::CMD_W-1:0]     r_cmd;
    logic [lpht_pkg::KEY_W-1:0]     r_key;
    logic [lpht_pkg::KEY_W-1:0]     r_quot;
    logic [WIDE_W-1:0]              r_diff;
    logic [1:0]                     r_mod_step;
    logic [SLOT_W-1:0]              r_rem;
    logic [SLOT_W-1:0]              r_slot;
    logic [SLOT_W-1:0]              r_probes;
    logic [SLOT_W-1:0]              r_sweep;
    logic [lpht_pkg::KEY_W-1:0]     r_rd_data;
    lpht_pkg::t_status              r_res_status;
    logic [lpht_pkg::POS_W-1:0]     r_res_pos;
    lpht_pkg::t_status              r_out_status;
    logic [lpht_pkg::POS_W-1:0]     r_out_pos;

    logic [PROD_W-1:0]          recip_prod;
    logic [lpht_pkg::KEY_W-1:0] quot_prod;
    logic [lpht_pkg::KEY_W-1:0] diff_full;
    logic [WIDE_W-1:0]          rem_fix;
    logic [SLOT_W-1:0]          slot_next;
    logic [SLOT_W-1:0]          rd_addr;
    logic                       wr_en;
    logic [SLOT_W-1:0]          wr_addr;
    logic [lpht_pkg::KEY_W-1:0] wr_data;
    logic                       cmd_insert;
    logic                       cmd_search;

    // quotient estimate, remainder, then one correcting subtract
    assign recip_prod = PROD_W'(r_key) * PROD_W'(RECIP);
    assign quot_prod  = r_quot * SIZE_KEY;
    assign diff_full  = r_key - quot_prod;
    assign rem_fix    = (r_diff >= SIZE_WIDE) ? (r_diff - SIZE_WIDE) : r_diff;

    assign slot_next = (r_slot == LAST_SLOT) ? '0 : (r_slot + SLOT_W'(1));
    assign rd_addr   = i_cmd.fetch ? r_rem : slot_next;

    always_comb begin
        cmd_insert = 1'b0;
        cmd_search = 1'b0;
        unique case (r_cmd)
            lpht_pkg::CMD_CLEAR:  ;
            lpht_pkg::CMD_INSERT: cmd_insert = 1'b1;
            lpht_pkg::CMD_SEARCH: cmd_search = 1'b1;
            default:              ;
        endcase
    end

    always_comb begin
        o_stat.is_clear    = (r_cmd == lpht_pkg::CMD_CLEAR);
        o_stat.is_insert   = cmd_insert;
        o_stat.is_invalid  = !(cmd_insert || cmd_search) || (r_key == '0);
        o_stat.sweep_last  = (r_sweep == LAST_SLOT);
        o_stat.mod_last    = (r_mod_step == MOD_LAST_STEP);
        o_stat.slot_empty  = (r_rd_data == '0);
        o_stat.slot_match  = (r_rd_data == r_key);
        o_stat.probes_last = (r_probes == LAST_SLOT);
    end

    always_comb begin
        wr_en   = i_cmd.clear_step || i_cmd.write_key;
        wr_addr = i_cmd.clear_step ? r_sweep : r_slot;
        wr_data = i_cmd.clear_step ? '0 : r_key;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.fetch || i_cmd.advance) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.clear_step) begin
            r_sweep <= (r_sweep == LAST_SLOT) ? '0 : (r_sweep + SLOT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd      <= i_command;
            r_key      <= i_key;
            r_mod_step <= '0;
        end else if (i_cmd.mod_step) begin
            r_mod_step <= r_mod_step + 2'd1;
            r_quot     <= recip_prod[PROD_W-1:RECIP_SHIFT];
            r_diff     <= diff_full[WIDE_W-1:0];
            r_rem      <= rem_fix[SLOT_W-1:0];
        end
        if (i_cmd.fetch) begin
            r_slot   <= r_rem;
            r_probes <= '0;
        end else if (i_cmd.advance) begin
            r_slot   <= slot_next;
            r_probes <= r_probes + SLOT_W'(1);
        end
        if (i_cmd.stage) begin
            r_res_status <= i_cmd.stage_status;
            r_res_pos    <= i_cmd.stage_use_slot ? lpht_pkg::POS_W'(r_slot) : '0;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_pos    <= r_res_pos;
        end
    end

    assign o_status   = r_out_status;
    assign o_position = r_out_pos;

endmodule

// ===== rtl/lpht_checker.sv =====
`timescale 1ns / 1ps
// port checker for the hash table top level, with its bind
module lpht_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [lpht_pkg::STATUS_W-1:0] o_status,
    input logic [lpht_pkg::POS_W-1:0]    o_position
);

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an item is in work");

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_position)))
        else $error("stalled result changed or dropped");

    // position only carries a slot on success
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != lpht_pkg::ST_OK)) |-> (o_position == '0))
        else $error("nonzero position on a failed item");

    // nothing pending or accepted right out of reset
    a_reset: assert property (@(posedge i_clk)
        ($past(!i_rst_n) && i_rst_n) |-> (!o_out_valid && !o_in_ready))
        else $error("block active directly after reset");

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_position  (o_position)
);
